/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block, dsl_checker.sv.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication on the following cycle, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dsl_pkg.sv */
// Package for the dense sigmoid layer: parameter defaults, codes and the
// elaboration-time sigmoid table generator. No dependencies.
`timescale 1ns / 1ps

package dsl_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_INPUTS_DEF  = 256;
  localparam int MAX_NEURONS_DEF = 256;
  localparam int SIG_DEPTH_DEF   = 1024;

  // Field widths fixed by the interface.
  localparam int CFG_W     = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int VALUE_W   = 16;
  localparam int INDEX_W   = 8;

  // Input item mode codes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  // Register index codes (paddr bit 2 selects the word).
  localparam logic REG_IN_SIZE  = 1'b0;
  localparam logic REG_OUT_SIZE = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

  // Shift-subtract long division, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid, Q1.15, at the center of table entry t (x in Q.16), through a Taylor
  // series of exp(-|x|/8) squared three times.
  function automatic logic [15:0] sig_entry(input int t, input int depth);
    longint      x;
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    longint      sm;
    x    = longint'(udiv64(64'((2 * t + 1)) * 64'd524288, 64'(depth))) - 64'sd524288;
    y    = (x < 0) ? 64'(-x) : 64'(x);
    sm   = 64'sd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 15; k++) begin
      term = udiv64(term * y, 64'd524288 * 64'(k));
      if ((k % 2) == 1) begin
        sm = sm - longint'(term);
      end else begin
        sm = sm + longint'(term);
      end
    end
    if (sm < 0) begin
      sm = 0;
    end
    e = 64'(sm);
    for (int k = 0; k < 3; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    d = (64'd1 << 30) + e;
    if (x >= 0) begin
      return 16'(udiv64((64'd1 << 45) + (d >> 1), d));
    end
    return 16'(udiv64((e << 15) + (d >> 1), d));
  endfunction

endpackage

/* hw/rtl/dense_sigmoid_layer_forward.sv */
// Top level of the dense sigmoid layer: activation store, multiply-accumulate
// pipeline, saturation and sigmoid ROM lookup. Depends on dsl_pkg.
`timescale 1ns / 1ps
//
//  Channel  Ports                                   Moves
//  -------  --------------------------------------  ------------------------------
//  input    in_valid/in_stall, in_mode/index/value   activation load or one weight
//  output   out_valid/out_stall, out_neuron_index,   one neuron result per row
//           out_activation, out_last_neuron
//  config   psel/penable/pwrite/paddr/pwdata/prdata  in_size at 0x0, out_size at 0x4
//
//  One item is taken every cycle while in_stall is low. A weight reads the store
//  at its transfer; its product is then registered and accumulated, and a row
//  result passes the saturation, table index and ROM registers to the outputs.
//  in_stall rises only while a stalled result sits in the output register and the
//  next result waits right behind it; then the whole pipe holds.
//  rst_n (sync) sets sizes to 256, clears counters, accumulator, valid flags only.
module dense_sigmoid_layer_forward #(
  parameter int MAX_INPUTS          = dsl_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NEURONS         = dsl_pkg::MAX_NEURONS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = dsl_pkg::SIG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [dsl_pkg::INDEX_W-1:0]       in_index,
  input  logic signed [dsl_pkg::VALUE_W-1:0] in_value,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dsl_pkg::INDEX_W-1:0]       out_neuron_index,
  output logic [dsl_pkg::VALUE_W-1:0]       out_activation,
  output logic                              out_last_neuron,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsl_pkg::PADDR_W-1:0]       paddr,
  input  logic [dsl_pkg::PDATA_W-1:0]       pwdata,
  output logic [dsl_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import dsl_pkg::*;

  localparam int AW    = $clog2(MAX_INPUTS);
  localparam int RW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int NI_W  = ($clog2(MAX_INPUTS + 1) > CFG_W) ? $clog2(MAX_INPUTS + 1) : CFG_W;
  localparam int NO_W  = ($clog2(MAX_NEURONS + 1) > CFG_W) ? $clog2(MAX_NEURONS + 1) : CFG_W;
  localparam int TW    = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int DW    = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int SAT_W = 31;

  typedef logic [VALUE_W-1:0] sig_rom_t [SIGMOID_TABLE_DEPTH];

  function automatic sig_rom_t build_rom();
    sig_rom_t rom;
    for (int t = 0; t < SIGMOID_TABLE_DEPTH; t++) begin
      rom[t] = sig_entry(t, SIGMOID_TABLE_DEPTH);
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_rom();

  // Configuration registers and read-back.
  logic [CFG_W-1:0] in_size_r;
  logic [CFG_W-1:0] out_size_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_size_r  <= SIZE_RESET;
      out_size_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IN_SIZE:  in_size_r  <= pwdata[CFG_W-1:0];
        REG_OUT_SIZE: out_size_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IN_SIZE:  prdata = PDATA_W'(in_size_r);
      REG_OUT_SIZE: prdata = PDATA_W'(out_size_r);
      default:      prdata = '0;
    endcase
  end

  // Pipeline hold: only a waiting result behind a stalled output freezes the pipe.
  logic hold_out;
  logic adv;
  logic v5_r;
  logic accept;

  assign hold_out = out_valid & out_stall;
  assign adv      = ~(hold_out & v5_r);
  assign in_stall = ~adv;
  assign accept   = in_valid & ~in_stall;

  // Effective sizes and row/layer end detection.
  logic [AW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [NI_W-1:0] n_in, col_inc;
  logic [NO_W-1:0] n_out, row_inc;
  logic            row_end, layer_end;
  logic            is_weight;

  always_comb begin
    if (in_size_r == '0) begin
      n_in = NI_W'(1);
    end else if (NI_W'(in_size_r) > NI_W'(MAX_INPUTS)) begin
      n_in = NI_W'(MAX_INPUTS);
    end else begin
      n_in = NI_W'(in_size_r);
    end
    if (out_size_r == '0) begin
      n_out = NO_W'(1);
    end else if (NO_W'(out_size_r) > NO_W'(MAX_NEURONS)) begin
      n_out = NO_W'(MAX_NEURONS);
    end else begin
      n_out = NO_W'(out_size_r);
    end
    col_inc   = NI_W'(col_r) + NI_W'(1);
    row_inc   = NO_W'(row_r) + NO_W'(1);
    row_end   = (col_inc >= n_in);
    layer_end = (row_inc >= n_out);
    col_nxt   = row_end ? '0 : AW'(col_inc);
    row_nxt   = row_end ? (layer_end ? '0 : RW'(row_inc)) : row_r;
  end

  assign is_weight = (in_mode == MODE_WEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept && is_weight) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Activation store: written by loads, read at the current column by weights.
  logic [VALUE_W-1:0] act_mem [MAX_INPUTS];
  logic [VALUE_W-1:0] act_q;
  logic               ld_we;
  logic               rd_en;

  assign ld_we = accept & (in_mode == MODE_LOAD) & (32'(in_index) < MAX_INPUTS);
  assign rd_en = accept & is_weight;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      act_mem[AW'(in_index)] <= in_value;
    end
    if (rd_en) begin
      act_q <= act_mem[col_r];
    end
  end

  // Stage 1: weight and row tags wait for the store read.
  logic signed [VALUE_W-1:0] w1_r;
  logic                      eor1_r, last1_r;
  logic [RW-1:0]             row1_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      w1_r    <= in_value;
      eor1_r  <= row_end;
      last1_r <= layer_end;
      row1_r  <= row_r;
    end
  end

  // Stage 2: activation times weight, exact.
  logic signed [32:0] prod2_r;
  logic               eor2_r, last2_r;
  logic [RW-1:0]      row2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2_r <= $signed({1'b0, act_q}) * w1_r;
      eor2_r  <= eor1_r;
      last2_r <= last1_r;
      row2_r  <= row1_r;
    end
  end

  // Stage valid flags.
  logic v1_r, v2_r, v3_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r & eor2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage 3: accumulate; at a row end saturate to +/-8 and clear the accumulator.
  logic signed [47:0] acc_r;
  logic signed [47:0] acc_sum;
  logic [SAT_W-1:0]   sat_off;
  logic [SAT_W-1:0]   sat3_r;
  logic               last3_r;
  logic [RW-1:0]      row3_r;

  always_comb begin
    acc_sum = acc_r + {{15{prod2_r[32]}}, prod2_r};
    if (acc_sum > 48'sh0000_3FFF_FFFF) begin
      sat_off = '1;
    end else if (acc_sum < -48'sh0000_4000_0000) begin
      sat_off = '0;
    end else begin
      sat_off = {~acc_sum[30], acc_sum[29:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (adv && v2_r) begin
      acc_r <= eor2_r ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat3_r  <= sat_off;
      last3_r <= last2_r;
      row3_r  <= row2_r;
    end
  end

  // Stage 4: table index = (sum + 8) * depth / 16.
  logic [SAT_W+DW-1:0] scaled;
  logic [DW-1:0]       t_raw;
  logic [TW-1:0]       idx4_r;
  logic                last4_r;
  logic [RW-1:0]       row4_r;

  assign scaled = (SAT_W+DW)'(sat3_r) * (SAT_W+DW)'(SIGMOID_TABLE_DEPTH);
  assign t_raw  = scaled[SAT_W+DW-1:SAT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      idx4_r  <= (t_raw >= DW'(SIGMOID_TABLE_DEPTH)) ? TW'(SIGMOID_TABLE_DEPTH - 1)
                                                     : TW'(t_raw);
      last4_r <= last3_r;
      row4_r  <= row3_r;
    end
  end

  // Stage 5: sigmoid ROM read.
  logic [VALUE_W-1:0] sig5_r;
  logic               last5_r;
  logic [RW-1:0]      row5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sig5_r  <= SIG_ROM[idx4_r];
      last5_r <= last4_r;
      row5_r  <= row4_r;
    end
  end

  // Output register; it loads whenever it is empty or its transfer completes.
  logic                 out_valid_r;
  logic [INDEX_W-1:0]   out_idx_r;
  logic [VALUE_W-1:0]   out_act_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!hold_out) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_out) begin
      out_idx_r  <= INDEX_W'(row5_r);
      out_act_r  <= sig5_r;
      out_last_r <= last5_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_neuron_index = out_idx_r;
  assign out_activation   = out_act_r;
  assign out_last_neuron  = out_last_r;

endmodule

/* hw/rtl/dsl_checker.sv */
// Port-level checks for the dense sigmoid layer, bound to the top level.
// Depends on dsl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_mode,
  input logic [dsl_pkg::INDEX_W-1:0]        in_index,
  input logic signed [dsl_pkg::VALUE_W-1:0] in_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [dsl_pkg::INDEX_W-1:0]        out_neuron_index,
  input logic [dsl_pkg::VALUE_W-1:0]        out_activation,
  input logic                               out_last_neuron,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [dsl_pkg::PADDR_W-1:0]        paddr,
  input logic [dsl_pkg::PDATA_W-1:0]        pwdata,
  input logic [dsl_pkg::PDATA_W-1:0]        prdata,
  input logic                               pready
);
  import dsl_pkg::*;

  logic wr_in_size;

  assign wr_in_size = psel & penable & pwrite & pready & (paddr[2] == REG_IN_SIZE);

  // A stalled result holds its valid and payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_activation) && $stable(out_neuron_index) && $stable(out_last_neuron), "stalled result changed")

  // The input side only stalls behind a stalled result.
  `ASSERT_IMPL(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // A sigmoid result never exceeds one in Q1.15.
  `ASSERT_IMPL(a_act_range, clk, rst_n, out_valid, out_activation <= 16'd32768, "activation above one")

  // A written in_size reads back on the next cycle.
  `ASSERT_IMPL(a_cfg_readback, clk, rst_n, $past(wr_in_size) && (paddr[2] == REG_IN_SIZE), prdata == PDATA_W'($past(pwdata[CFG_W-1:0])), "in_size read-back mismatch")

endmodule

bind dense_sigmoid_layer_forward dsl_checker u_dsl_checker (.*);

/* dv/dsl_layer_checker.sv */
// Passive checker for the dense sigmoid layer: watches the input, result and
// register ports, predicts each neuron result and compares it field by field.
// Depends on dsl_pkg for widths, mode codes and register codes.
`timescale 1ns / 1ps

module dsl_layer_checker #(
  parameter int MAX_INPUTS          = dsl_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NEURONS         = dsl_pkg::MAX_NEURONS_DEF,
  parameter int SIGMOID_TABLE_DEPTH = dsl_pkg::SIG_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_mode,
  input  logic [dsl_pkg::INDEX_W-1:0]        in_index,
  input  logic signed [dsl_pkg::VALUE_W-1:0] in_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [dsl_pkg::INDEX_W-1:0]        out_neuron_index,
  input  logic [dsl_pkg::VALUE_W-1:0]        out_activation,
  input  logic                               out_last_neuron,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [dsl_pkg::PADDR_W-1:0]        paddr,
  input  logic [dsl_pkg::PDATA_W-1:0]        pwdata,
  output int                                 fail_count,
  output int                                 pending_results,
  output int                                 results_checked
);
  import dsl_pkg::*;

  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [INDEX_W-1:0] neuron;
    logic [VALUE_W-1:0] level;
    logic               is_last;
  } neuron_result_t;

  logic [VALUE_W-1:0] sig_rom [SIGMOID_TABLE_DEPTH];
  logic [VALUE_W-1:0] act_store [MAX_INPUTS];
  logic signed [47:0] row_sum;
  int                 col_pos;
  int                 row_pos;
  logic [CFG_W-1:0]   in_size_reg;
  logic [CFG_W-1:0]   out_size_reg;
  neuron_result_t     expected_neurons [$];

  // Sigmoid at x (Q.16), through a Taylor series of exp(-|x|/8) squared three times.
  function automatic logic [VALUE_W-1:0] sigmoid_q15(input longint xq);
    longint unsigned mag;
    longint unsigned term;
    longint unsigned e_pow;
    longint unsigned den;
    longint          series;
    mag    = (xq < 0) ? -xq : xq;
    series = ONE_Q30;
    term   = ONE_Q30;
    for (int k = 1; k <= 15; k++) begin
      term = (term * mag) / (64'd524288 * 64'(k));
      if ((k % 2) == 1) begin
        series = series - longint'(term);
      end else begin
        series = series + longint'(term);
      end
    end
    if (series < 0) begin
      series = 0;
    end
    e_pow = series;
    for (int k = 0; k < 3; k++) begin
      e_pow = (e_pow * e_pow + (64'd1 << 29)) >> 30;
    end
    den = 64'd1073741824 + e_pow;
    if (xq >= 0) begin
      return 16'(((64'd1 << 45) + den / 2) / den);
    end
    return 16'(((e_pow << 15) + den / 2) / den);
  endfunction

  // Register values outside the legal range act as the nearest legal size.
  function automatic int effective_size(input logic [CFG_W-1:0] v, input int max_v);
    if (v == 0) begin
      return 1;
    end
    return (int'(v) > max_v) ? max_v : int'(v);
  endfunction

  // The lookup contents are fixed, so build them once at time zero.
  initial begin
    for (int t = 0; t < SIGMOID_TABLE_DEPTH; t++) begin
      sig_rom[t] = sigmoid_q15((longint'(2 * t + 1) * 64'sd524288) / SIGMOID_TABLE_DEPTH
                               - 64'sd524288);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Apply one input transfer: store an activation, or accumulate one weight and
  // queue the neuron result when the row completes.
  task automatic step_layer(input logic mode, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] raw);
    longint         prod;
    longint         sum;
    int             n_in;
    int             n_out;
    int             t;
    neuron_result_t res;
    n_in  = effective_size(in_size_reg, MAX_INPUTS);
    n_out = effective_size(out_size_reg, MAX_NEURONS);
    if (mode == MODE_LOAD) begin
      if (int'(idx) < MAX_INPUTS) begin
        act_store[idx] = raw;
      end
      return;
    end
    prod    = longint'({48'd0, act_store[col_pos]}) * longint'($signed(raw));
    row_sum = row_sum + prod[47:0];
    if (col_pos + 1 < n_in) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    // Saturate to the table's input range of plus or minus eight.
    sum = longint'(row_sum);
    if (sum > ONE_Q30 - 1) begin
      sum = ONE_Q30 - 1;
    end
    if (sum < -ONE_Q30) begin
      sum = -ONE_Q30;
    end
    t = int'(((sum + ONE_Q30) * SIGMOID_TABLE_DEPTH) >>> 31);
    if (t >= SIGMOID_TABLE_DEPTH) begin
      t = SIGMOID_TABLE_DEPTH - 1;
    end
    row_sum         = '0;
    res.neuron      = row_pos[INDEX_W-1:0];
    res.level       = sig_rom[t];
    res.is_last     = (row_pos + 1 >= n_out);
    row_pos         = res.is_last ? 0 : row_pos + 1;
    expected_neurons.push_back(res);
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_neuron();
    neuron_result_t want;
    if (expected_neurons.size() == 0) begin
      report_mismatch("unexpected result, neuron_index", out_neuron_index, -1);
      return;
    end
    want = expected_neurons.pop_front();
    results_checked++;
    if (out_neuron_index !== want.neuron) begin
      report_mismatch("neuron_index", out_neuron_index, want.neuron);
    end
    if (out_activation !== want.level) begin
      report_mismatch("activation", out_activation, want.level);
    end
    if (out_last_neuron !== want.is_last) begin
      report_mismatch("last_neuron", out_last_neuron, want.is_last);
    end
  endtask

  initial begin
    fail_count      = 0;
    results_checked = 0;
    pending_results = 0;
  end

  // Track register writes, input transfers and result transfers at each edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      row_sum      = '0;
      col_pos      = 0;
      row_pos      = 0;
      in_size_reg  = SIZE_RESET;
      out_size_reg = SIZE_RESET;
      expected_neurons.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_IN_SIZE) begin
          in_size_reg = pwdata[CFG_W-1:0];
        end else begin
          out_size_reg = pwdata[CFG_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        step_layer(in_mode, in_index, in_value);
      end
      if (out_valid && !out_stall) begin
        check_neuron();
      end
    end
    pending_results <= expected_neurons.size();
  end

endmodule

/* dv/dense_sigmoid_layer_forward_tb.sv */
// Testbench top for the dense sigmoid layer: clock, reset, register writes,
// input and result traffic, and the verdict. Depends on dsl_pkg, the block
// and dsl_layer_checker.
`timescale 1ns / 1ps

module dense_sigmoid_layer_forward_tb;
  import dsl_pkg::*;

  localparam int ITEM_TARGET  = 850;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 12;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_mode;
  logic [INDEX_W-1:0]        in_index;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [INDEX_W-1:0]        out_neuron_index;
  logic [VALUE_W-1:0]        out_activation;
  logic                      out_last_neuron;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  int fail_count;
  int pending_results;
  int results_checked;

  // Stimulus-side view of the store and the column position, so that no weight
  // ever reads a slot that was never loaded.
  bit   slot_written [256];
  int   col_mirror;
  int   eff_in;
  int   n_loads;
  int   n_weights;
  int   n_settings;
  bit   noise_on;
  logic burst_phase;

  always #5 clk = ~clk;

  dense_sigmoid_layer_forward u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_index         (in_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_neuron_index (out_neuron_index),
    .out_activation   (out_activation),
    .out_last_neuron  (out_last_neuron),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  dsl_layer_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_index         (in_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_neuron_index (out_neuron_index),
    .out_activation   (out_activation),
    .out_last_neuron  (out_last_neuron),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .results_checked  (results_checked)
  );

  function automatic int clamp_size(input int v);
    if (v == 0) begin
      return 1;
    end
    return (v > 256) ? 256 : v;
  endfunction

  // Half the weights span the full range, half stay small so sums land mid-curve.
  function automatic logic [VALUE_W-1:0] random_weight();
    if ($urandom_range(1) == 1) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(511) - 256);
  endfunction

  // Register write: setup cycle, access cycle until pready, then back to idle.
  task automatic write_reg(input logic reg_sel, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(input int in_v, input int out_v);
    write_reg(REG_IN_SIZE, PDATA_W'(in_v));
    write_reg(REG_OUT_SIZE, PDATA_W'(out_v));
    eff_in = clamp_size(in_v);
    n_settings++;
  endtask

  // One input transfer, with random idle cycles ahead of it outside the burst.
  task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val);
    while (!burst_phase && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_slot(input int idx, input logic [VALUE_W-1:0] val);
    slot_written[idx] = 1'b1;
    send_item(MODE_LOAD, INDEX_W'(idx), val);
    n_loads++;
  endtask

  // A weight, preceded by occasional stray loads and by a load of the current
  // column's slot if it was never written.
  task automatic send_weight(input logic [VALUE_W-1:0] val);
    if (noise_on && $urandom_range(99) < 8) begin
      load_slot($urandom_range(255), 16'($urandom));
    end
    if (!slot_written[col_mirror]) begin
      load_slot(col_mirror, 16'($urandom));
    end
    send_item(MODE_WEIGHT, INDEX_W'($urandom_range(255)), val);
    n_weights++;
    col_mirror = (col_mirror + 1 < eff_in) ? col_mirror + 1 : 0;
  endtask

  // Drop valid, wait for every predicted result (bounded by DRAIN_LIMIT), then idle.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: one long hold-off at the start of the burst, no stalls for the
  // rest of it, random stalls elsewhere.
  initial begin
    int held;
    held = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (burst_phase && held < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else if (burst_phase) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 9);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    int in_v;
    int out_v;
    int n_w;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= MODE_LOAD;
    in_index    <= '0;
    in_value    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    burst_phase <= 1'b0;
    col_mirror  = 0;
    eff_in      = 256;
    n_loads     = 0;
    n_weights   = 0;
    n_settings  = 0;
    noise_on    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: three inputs, two neurons, extreme activations and weights.
    set_sizes(3, 2);
    load_slot(0, 16'h0000);
    load_slot(1, 16'h8000);
    load_slot(2, 16'hFFFF);
    load_slot(255, 16'h7FFF);
    // Largest positive weights saturate the sum high.
    repeat (3) send_weight(16'h7FFF);
    // Most negative weights saturate it low on the last neuron.
    repeat (3) send_weight(16'h8000);
    // All-zero row lands at the middle of the curve; the row count wraps.
    repeat (3) send_weight(16'h0000);
    // A load between weights of one row is seen by the later weights.
    send_weight(16'h1000);
    load_slot(1, 16'h4000);
    send_weight(16'hF000);
    send_weight(16'h0001);
    settle();

    // Random phases, each under its own sizes; a few fixed ones hit the extremes.
    noise_on = 1'b1;
    phase = 0;
    while (phase < 6 || n_loads + n_weights < ITEM_TARGET) begin
      case (phase)
        1: begin
          in_v  = 0;
          out_v = 511;
          n_w   = 260;
        end
        3: begin
          in_v  = 2;
          out_v = 0;
          n_w   = 2 * $urandom_range(5, 2);
        end
        4: begin
          in_v  = 256;
          out_v = 256;
          n_w   = 256;
        end
        5: begin
          in_v  = 511;
          out_v = 1;
          n_w   = $urandom_range(40, 20);
        end
        default: begin
          in_v  = ($urandom_range(5) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
          out_v = $urandom_range(6, 1);
          n_w   = in_v * out_v * $urandom_range(3, 1);
          // Sometimes stop in the middle of a row.
          if ($urandom_range(3) == 0) begin
            n_w = n_w + $urandom_range(in_v, 1);
          end
        end
      endcase
      set_sizes(in_v, out_v);
      if (phase == 1) begin
        burst_phase <= 1'b1;
        noise_on = 1'b0;
      end
      repeat (n_w) send_weight(random_weight());
      burst_phase <= 1'b0;
      noise_on = 1'b1;
      settle();
      phase++;
    end

    $display("Covered %0d activation loads and %0d weights under %0d size settings,",
             n_loads, n_weights, n_settings);
    $display("out-of-range sizes and a long result hold-off included; %0d results checked.",
             results_checked);
    if (pending_results != 0) begin
      $display("%0d predicted results never arrived", pending_results);
    end
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending_results);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dsl_pkg.sv
hw/rtl/dense_sigmoid_layer_forward.sv
hw/rtl/dsl_checker.sv
dv/dsl_layer_checker.sv
dv/dense_sigmoid_layer_forward_tb.sv
